// ----- sv/access_point_table_top_two_top_macros.svh -----
`ifndef ACCESS_POINT_TABLE_TOP_TWO_TOP_MACROS_SVH
`define ACCESS_POINT_TABLE_TOP_TWO_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define APT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define APT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/apt_pkg.sv -----
package apt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int MAC_W       = 48;
    localparam int STR_W       = 8;
    localparam int RSSI_W      = 11;
    localparam int STATUS_W    = 3;
    localparam int ECOUNT_W    = 5;
    localparam int BCOUNT_W    = 2;
    localparam int MCAST_BIT   = 40;

    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 104;

    localparam logic [STATUS_W-1:0] STAT_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RAISED    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_UNCHANGED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_MCAST     = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_QUERY     = 3'd5;

    localparam logic [BCOUNT_W-1:0] BEST_NONE = 2'd0;
    localparam logic [BCOUNT_W-1:0] BEST_ONE  = 2'd1;
    localparam logic [BCOUNT_W-1:0] BEST_TWO  = 2'd2;

    typedef logic signed [STR_W-1:0] t_str;

    localparam t_str STR_MIN = t_str'(-128);
    localparam t_str STR_MAX = t_str'(127);
    localparam logic signed [RSSI_W-1:0] RSSI_LO = RSSI_W'(-128);
    localparam logic signed [RSSI_W-1:0] RSSI_HI = RSSI_W'(127);

    typedef struct packed {
        logic mac_eq;
        logic str_gt;
        logic ge_first;
        logic ge_second;
    } t_cmp;

    function automatic t_str sat_str(input logic signed [RSSI_W-1:0] raw);
        t_str r;
        if (raw < RSSI_LO) begin
            r = STR_MIN;
        end else if (raw > RSSI_HI) begin
            r = STR_MAX;
        end else begin
            r = t_str'(raw[STR_W-1:0]);
        end
        return r;
    endfunction

endpackage

// ----- sv/apt_store.sv -----
module apt_store (
    input  logic                        i_clk,
    input  logic                        i_we_mac,
    input  logic                        i_we_str,
    input  logic [apt_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [apt_pkg::MAC_W-1:0]   i_wmac,
    input  apt_pkg::t_str               i_wstr,
    input  logic [apt_pkg::ADDR_W-1:0]  i_raddr,
    output logic [apt_pkg::MAC_W-1:0]   o_rmac,
    output apt_pkg::t_str               o_rstr
);
    import apt_pkg::*;

    logic [MAC_W-1:0] r_mac_mem [MAX_ENTRIES];
    t_str             r_str_mem [MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we_mac) begin
            r_mac_mem[i_waddr] <= i_wmac;
        end
        if (i_we_str) begin
            r_str_mem[i_waddr] <= i_wstr;
        end
        o_rmac <= r_mac_mem[i_raddr];
        o_rstr <= r_str_mem[i_raddr];
    end

endmodule

// ----- sv/apt_cmp.sv -----
module apt_cmp (
    input  logic [apt_pkg::MAC_W-1:0] i_key_mac,
    input  apt_pkg::t_str             i_key_str,
    input  logic [apt_pkg::MAC_W-1:0] i_ent_mac,
    input  apt_pkg::t_str             i_ent_str,
    input  apt_pkg::t_str             i_first_s,
    input  apt_pkg::t_str             i_second_s,
    output apt_pkg::t_cmp             o_res
);
    import apt_pkg::*;

    always_comb begin
        o_res.mac_eq    = (i_key_mac == i_ent_mac);
        o_res.str_gt    = (i_key_str > i_ent_str);
        o_res.ge_first  = (i_ent_str >= i_first_s);
        o_res.ge_second = (i_ent_str >= i_second_s);
    end

endmodule

// ----- sv/access_point_table_top_two_top.sv -----
// Each item is taken in IDLE, scanned against the table in SCAN and put out from DONE;
// a multicast add dropped under unicast_only skips the scan, and a hit on an add ends it early.
// A new input beat is taken only in IDLE, once the last item has left DONE; the scan reads
// one entry per cycle through the single table read port; a held output beat stalls the input.
// Reset: i_rst_n synchronous, active low; clears the entry count, the sequencer,
// the output valid and unicast_only. Table contents stay undefined until written.
`include "access_point_table_top_two_top_macros.svh"

module access_point_table_top_two_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_data,     // unicast_only
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [apt_pkg::S_TDATA_W-1:0]  i_s_axis_tdata, // mac, rssi, zero pad
    input  logic [0:0]                     i_s_axis_tuser, // req_type
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [apt_pkg::M_TDATA_W-1:0]  o_m_axis_tdata, // entry_count, best_count,
                                                           // best_mac, second_mac, zero pad
    output logic [apt_pkg::STATUS_W-1:0]   o_m_axis_tuser  // status
);
    import apt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          r_state, n_state;
    logic                r_cfg_uni, n_cfg_uni;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic                r_pend, n_pend;
    logic                r_out_valid, n_out_valid;

    logic                r_req, n_req;
    logic [MAC_W-1:0]    r_mac, n_mac;
    t_str                r_str, n_str;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [ADDR_W-1:0]   r_pend_idx, n_pend_idx;
    t_str                r_first_s, n_first_s;
    t_str                r_second_s, n_second_s;
    logic [MAC_W-1:0]    r_first_mac, n_first_mac;
    logic [MAC_W-1:0]    r_second_mac, n_second_mac;

    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [BCOUNT_W-1:0] r_res_bcount, n_res_bcount;
    logic [MAC_W-1:0]    r_res_best, n_res_best;
    logic [MAC_W-1:0]    r_res_second, n_res_second;

    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [ECOUNT_W-1:0] r_out_count, n_out_count;
    logic [BCOUNT_W-1:0] r_out_bcount, n_out_bcount;
    logic [MAC_W-1:0]    r_out_best, n_out_best;
    logic [MAC_W-1:0]    r_out_second, n_out_second;

    logic                we_mac;
    logic                we_str;
    logic [ADDR_W-1:0]   waddr;
    logic [MAC_W-1:0]    rd_mac;
    t_str                rd_str;
    t_cmp                cmp;

    logic [MAC_W-1:0]    in_mac;
    logic [RSSI_W-1:0]   in_rssi;
    logic                in_beat;

    assign in_mac  = i_s_axis_tdata[MAC_W-1:0];
    assign in_rssi = i_s_axis_tdata[MAC_W+RSSI_W-1:MAC_W];
    assign in_beat = i_s_axis_tvalid && o_s_axis_tready;

    apt_store u_store (
        .i_clk    (i_clk),
        .i_we_mac (we_mac),
        .i_we_str (we_str),
        .i_waddr  (waddr),
        .i_wmac   (r_mac),
        .i_wstr   (r_str),
        .i_raddr  (r_idx[ADDR_W-1:0]),
        .o_rmac   (rd_mac),
        .o_rstr   (rd_str)
    );

    apt_cmp u_cmp (
        .i_key_mac  (r_mac),
        .i_key_str  (r_str),
        .i_ent_mac  (rd_mac),
        .i_ent_str  (rd_str),
        .i_first_s  (r_first_s),
        .i_second_s (r_second_s),
        .o_res      (cmp)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {{(M_TDATA_W-ECOUNT_W-BCOUNT_W-2*MAC_W){1'b0}},
                              r_out_second, r_out_best, r_out_bcount, r_out_count};

    always_comb begin
        n_state      = r_state;
        n_cfg_uni    = r_cfg_uni;
        n_fill       = r_fill;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_req        = r_req;
        n_mac        = r_mac;
        n_str        = r_str;
        n_idx        = r_idx;
        n_pend_idx   = r_pend_idx;
        n_first_s    = r_first_s;
        n_second_s   = r_second_s;
        n_first_mac  = r_first_mac;
        n_second_mac = r_second_mac;
        n_res_status = r_res_status;
        n_res_bcount = r_res_bcount;
        n_res_best   = r_res_best;
        n_res_second = r_res_second;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_bcount = r_out_bcount;
        n_out_best   = r_out_best;
        n_out_second = r_out_second;
        we_mac       = 1'b0;
        we_str       = 1'b0;
        waddr        = r_pend ? r_pend_idx : r_fill[ADDR_W-1:0];

        if (i_cfg_valid) begin
            n_cfg_uni = i_cfg_data;
        end
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_req        = i_s_axis_tuser[0];
                    n_mac        = in_mac;
                    n_str        = sat_str(in_rssi);
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    n_first_s    = STR_MIN;
                    n_second_s   = STR_MIN;
                    n_first_mac  = '0;
                    n_second_mac = '0;
                    n_res_bcount = BEST_NONE;
                    n_res_best   = '0;
                    n_res_second = '0;
                    if (!i_s_axis_tuser[0] && r_cfg_uni && in_mac[MCAST_BIT]) begin
                        n_res_status = STAT_MCAST;
                        n_state      = ST_DONE;
                    end else begin
                        n_state      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx < r_fill) begin
                    n_idx      = r_idx + 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[ADDR_W-1:0];
                end else begin
                    n_pend     = 1'b0;
                end
                if (r_pend) begin
                    if (!r_req) begin
                        if (cmp.mac_eq) begin
                            if (cmp.str_gt) begin
                                we_str       = 1'b1;
                                n_res_status = STAT_RAISED;
                            end else begin
                                n_res_status = STAT_UNCHANGED;
                            end
                            n_pend  = 1'b0;
                            n_state = ST_DONE;
                        end
                    end else begin
                        priority if (cmp.ge_first) begin
                            n_second_s   = r_first_s;
                            n_second_mac = r_first_mac;
                            n_first_s    = rd_str;
                            n_first_mac  = rd_mac;
                        end else if (cmp.ge_second) begin
                            n_second_s   = rd_str;
                            n_second_mac = rd_mac;
                        end else begin
                            n_second_s   = r_second_s;
                        end
                    end
                end else if (r_idx >= r_fill) begin
                    n_state = ST_DONE;
                    if (!r_req) begin
                        if (r_fill == CNT_W'(MAX_ENTRIES)) begin
                            n_res_status = STAT_FULL;
                        end else begin
                            we_mac       = 1'b1;
                            we_str       = 1'b1;
                            n_fill       = r_fill + 1'b1;
                            n_res_status = STAT_ADDED;
                        end
                    end else begin
                        n_res_status = STAT_QUERY;
                        priority if (r_fill >= CNT_W'(2)) begin
                            n_res_bcount = BEST_TWO;
                            n_res_best   = r_first_mac;
                            n_res_second = r_second_mac;
                        end else if (r_fill == CNT_W'(1)) begin
                            n_res_bcount = BEST_ONE;
                            n_res_best   = r_first_mac;
                        end else begin
                            n_res_bcount = BEST_NONE;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_count  = ECOUNT_W'(r_fill);
                    n_out_bcount = r_res_bcount;
                    n_out_best   = r_res_best;
                    n_out_second = r_res_second;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_uni   <= 1'b0;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg_uni   <= n_cfg_uni;
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_mac        <= n_mac;
        r_str        <= n_str;
        r_idx        <= n_idx;
        r_pend_idx   <= n_pend_idx;
        r_first_s    <= n_first_s;
        r_second_s   <= n_second_s;
        r_first_mac  <= n_first_mac;
        r_second_mac <= n_second_mac;
        r_res_status <= n_res_status;
        r_res_bcount <= n_res_bcount;
        r_res_best   <= n_res_best;
        r_res_second <= n_res_second;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_bcount <= n_out_bcount;
        r_out_best   <= n_out_best;
        r_out_second <= n_out_second;
    end

    `APT_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= CNT_W'(MAX_ENTRIES), "fill count over depth")
    `APT_ASSERT_NEXT(a_busy_after_beat, in_beat, !o_s_axis_tready, "ready after input beat")
    `APT_ASSERT_NEXT(a_fill_step, we_mac, r_fill == $past(r_fill) + 1'b1, "no count step")
    `APT_ASSERT_NOW(a_append_room, we_mac, r_fill < CNT_W'(MAX_ENTRIES), "append into full table")
    `APT_ASSERT_NOW(a_append_scan, we_mac, r_state == ST_SCAN, "append outside scan")

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import apt_pkg::*;

    localparam logic REQ_ADD     = 1'b0;
    localparam logic REQ_QUERY   = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   PLAN_ITEMS  = 1350;

    typedef struct packed {
        logic                     req;
        logic [MAC_W-1:0]         mac;
        logic signed [RSSI_W-1:0] rssi;
    } t_ap_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ECOUNT_W-1:0] count;
        logic [BCOUNT_W-1:0] best_n;
        logic [MAC_W-1:0]    best;
        logic [MAC_W-1:0]    second;
    } t_ap_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_data = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic [0:0]             i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;
    logic [STATUS_W-1:0]    o_m_axis_tuser;

    access_point_table_top_two_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    t_ap_item         pending_q[$];
    t_ap_result       expected_q[$];
    logic [MAC_W-1:0] known_macs[$];

    logic [MAC_W-1:0] tbl_mac[MAX_ENTRIES];
    t_str             tbl_str[MAX_ENTRIES];
    int               tbl_fill = 0;
    logic             unicast_mode = 1'b0;

    bit offer_live = 0;
    int send_idle_pct = 19;
    int recv_idle_pct = 19;
    int hold_left = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int gen_total = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_ap_result predict_item(input t_ap_item it);
        t_ap_result r;
        t_str       s;
        t_str       top_s;
        t_str       next_s;
        int         top_i;
        int         next_i;
        int         rv;
        bit         hit;
        r = '0;
        if (it.req == REQ_QUERY) begin
            r.status = STAT_QUERY;
            if (tbl_fill == 1) begin
                r.best_n = BEST_ONE;
                r.best   = tbl_mac[0];
            end else if (tbl_fill >= 2) begin
                top_i  = 0;
                next_i = 0;
                top_s  = STR_MIN;
                next_s = STR_MIN;
                for (int i = 0; i < tbl_fill; i++) begin
                    if (tbl_str[i] >= top_s) begin
                        next_i = top_i;
                        next_s = top_s;
                        top_i  = i;
                        top_s  = tbl_str[i];
                    end else if (tbl_str[i] >= next_s) begin
                        next_i = i;
                        next_s = tbl_str[i];
                    end
                end
                r.best_n = BEST_TWO;
                r.best   = tbl_mac[top_i];
                r.second = tbl_mac[next_i];
            end
        end else if (unicast_mode && it.mac[MCAST_BIT]) begin
            r.status = STAT_MCAST;
        end else begin
            rv = $signed(it.rssi);
            if (rv < -128) begin
                s = STR_MIN;
            end else if (rv > 127) begin
                s = STR_MAX;
            end else begin
                s = t_str'(rv);
            end
            hit      = 0;
            r.status = STAT_FULL;
            for (int i = 0; i < tbl_fill; i++) begin
                if (!hit && tbl_mac[i] == it.mac) begin
                    hit = 1;
                    if (s > tbl_str[i]) begin
                        tbl_str[i] = s;
                        r.status   = STAT_RAISED;
                    end else begin
                        r.status = STAT_UNCHANGED;
                    end
                end
            end
            if (!hit && tbl_fill < MAX_ENTRIES) begin
                tbl_mac[tbl_fill] = it.mac;
                tbl_str[tbl_fill] = s;
                tbl_fill++;
                r.status = STAT_ADDED;
            end
        end
        r.count = ECOUNT_W'(tbl_fill);
        return r;
    endfunction

    function automatic t_ap_item make_item(input logic req, input logic [MAC_W-1:0] mac,
                                           input int rssi);
        t_ap_item it;
        it.req  = req;
        it.mac  = mac;
        it.rssi = RSSI_W'(rssi);
        return it;
    endfunction

    function automatic logic [MAC_W-1:0] any_mac();
        return {16'($urandom()), $urandom()};
    endfunction

    // strengths creep upward over the run so that refreshes keep raising entries
    task automatic push_random(input int n);
        int               roll;
        int               ceil_s;
        logic [MAC_W-1:0] m;
        for (int k = 0; k < n; k++) begin
            roll   = $urandom_range(99);
            ceil_s = -128 + (gen_total * 255) / PLAN_ITEMS;
            if (ceil_s > 127) begin
                ceil_s = 127;
            end
            if (roll < 25) begin
                pending_q.push_back(make_item(REQ_QUERY, any_mac(),
                                              int'($urandom_range(2047)) - 1024));
            end else if (roll < 35) begin
                m = (known_macs.size() > 0 && $urandom_range(1))
                    ? known_macs[$urandom_range(known_macs.size() - 1)] : any_mac();
                pending_q.push_back(make_item(REQ_ADD, m, int'($urandom_range(2047)) - 1024));
            end else if (roll < 60 || known_macs.size() == 0) begin
                m = any_mac();
                known_macs.push_back(m);
                pending_q.push_back(make_item(REQ_ADD, m,
                                              ceil_s - 8 + int'($urandom_range(12))));
            end else begin
                m = known_macs[$urandom_range(known_macs.size() - 1)];
                pending_q.push_back(make_item(REQ_ADD, m,
                                              ceil_s - 8 + int'($urandom_range(12))));
            end
            gen_total++;
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || offer_live || expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_unicast_only(input logic val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        unicast_mode = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [MAC_W-1:0] want,
                               input logic [MAC_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // driver: hold a beat until it is taken
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            expected_q.push_back(predict_item(pending_q[0]));
            pending_q.pop_front();
            offer_live = 0;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !offer_live) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_axis_tdata  <= {5'b0, pending_q[0].rssi, pending_q[0].mac};
                i_s_axis_tuser  <= pending_q[0].req;
                i_s_axis_tvalid <= 1'b1;
                offer_live = 1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: long hold-off while hold_left runs down, random idling otherwise
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_ap_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %0h", $time,
                         o_m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("status", MAC_W'(want.status), MAC_W'(o_m_axis_tuser));
                check_field("entry_count", MAC_W'(want.count), MAC_W'(o_m_axis_tdata[4:0]));
                check_field("best_count", MAC_W'(want.best_n), MAC_W'(o_m_axis_tdata[6:5]));
                check_field("best_mac", want.best, o_m_axis_tdata[54:7]);
                check_field("second_mac", want.second, o_m_axis_tdata[102:55]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pending_q.push_back(make_item(REQ_QUERY, '0, 0));
        pending_q.push_back(make_item(REQ_ADD, 48'h00_11_22_33_44_55, -1024));
        pending_q.push_back(make_item(REQ_QUERY, '0, 0));
        pending_q.push_back(make_item(REQ_ADD, 48'h00_11_22_33_44_55, 1023));
        pending_q.push_back(make_item(REQ_ADD, 48'h00_11_22_33_44_55, 127));
        pending_q.push_back(make_item(REQ_ADD, 48'h00_11_22_33_44_55, 500));
        pending_q.push_back(make_item(REQ_ADD, 48'h02_AB_CD_EF_01_23, -129));
        pending_q.push_back(make_item(REQ_ADD, 48'h02_AB_CD_EF_01_23, -128));
        pending_q.push_back(make_item(REQ_ADD, 48'h02_AB_CD_EF_01_23, -127));
        pending_q.push_back(make_item(REQ_ADD, 48'h01_00_5E_00_00_FB, 128));
        pending_q.push_back(make_item(REQ_QUERY, '0, 0));
        pending_q.push_back(make_item(REQ_ADD, 48'h0, 0));
        pending_q.push_back(make_item(REQ_ADD, 48'hFF_FF_FF_FF_FF_FF, -1));
        pending_q.push_back(make_item(REQ_QUERY, 48'hFF_FF_FF_FF_FF_FF, -1));
        wait_drained();

        write_unicast_only(1'b1);
        pending_q.push_back(make_item(REQ_ADD, 48'h33_33_00_00_00_01, 10));
        pending_q.push_back(make_item(REQ_ADD, 48'h01_00_5E_00_00_FB, 5));
        pending_q.push_back(make_item(REQ_ADD, 48'hA4_5E_60_12_34_56, -50));
        pending_q.push_back(make_item(REQ_QUERY, '0, 0));
        wait_drained();

        write_unicast_only(1'b0);
        push_random(270);
        wait_drained();

        write_unicast_only(1'b1);
        push_random(270);
        hold_left = 400;
        wait_drained();

        write_unicast_only(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(270);
        wait_drained();

        write_unicast_only(1'b1);
        send_idle_pct = 19;
        recv_idle_pct = 19;
        push_random(270);
        wait_drained();

        write_unicast_only(1'b0);
        push_random(250);
        wait_drained();

        repeat (24) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
